// ----- hw/rtl/fip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_pkg: shared constants and functions
// Widths, key salts and codes for the keyed index permutation.
// ----------------------------------------------------------------------------
package fip_pkg;

  localparam int IDX_BITS    = 48;
  localparam int ROUND_COUNT = 6;

  localparam int WORD_W  = 64;                  // mix word
  localparam int RNG_W   = IDX_BITS + 1;        // range / divisor width
  localparam int SQ_W    = IDX_BITS / 2;        // integer square root width
  localparam int SIDE_W  = SQ_W + 1;            // side sizes a and b
  localparam int RND_W   = 4;                   // round counter
  localparam int PROD_W  = 2 * SIDE_W;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 1'b1;

  localparam logic [RNG_W-1:0] EFF_MAX = RNG_W'(1) << IDX_BITS;

  function automatic logic [WORD_W-1:0] key_salt(input logic [1:0] k);
    logic [WORD_W-1:0] s;
    case (k)
      2'd0:    s = 64'h736f6d6570736575;
      2'd1:    s = 64'h646f72616e646f6d;
      2'd2:    s = 64'h6c7967656e657261;
      default: s = 64'h7465646279746573;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/fip_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_in_if: index input channel
// valid/ready handshake carrying one index per transfer.
// ----------------------------------------------------------------------------
interface fip_in_if import fip_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

// ----- hw/rtl/fip_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_out_if: permuted result channel
// valid/ready handshake carrying one permuted position per transfer.
// ----------------------------------------------------------------------------
interface fip_out_if import fip_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] permuted;

  modport source (output valid, output permuted, input ready);
  modport sink   (input valid, input permuted, output ready);
endinterface

// ----- hw/rtl/fip_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_div: bit-serial restoring divider
// One quotient bit per cycle; done rises once the last quotient bit is in.
// ----------------------------------------------------------------------------
module fip_div import fip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [RNG_W-1:0]  divisor,
  output logic              done,
  output logic [WORD_W-1:0] quot,
  output logic [RNG_W-1:0]  rem
);

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] n_r, n_nxt;
  logic [RNG_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RNG_W:0]    sh;
  logic              qbit;

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, n_r[WORD_W-1]};
    qbit     = (sh >= {1'b0, divisor});
    if (start) begin
      n_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? RNG_W'(sh - {1'b0, divisor}) : sh[RNG_W-1:0];
      n_nxt   = {n_r[WORD_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = n_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/fip_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_isqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module fip_isqrt import fip_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [IDX_BITS-1:0] radicand,
  output logic                done,
  output logic [SQ_W-1:0]     root
);

  localparam int CNT_W = $clog2(SQ_W);
  localparam int REM_W = SQ_W + 2;

  logic [IDX_BITS-1:0] x_r, x_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [SQ_W-1:0]     root_r, root_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [REM_W:0]      sh;
  logic [REM_W:0]      trial;

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[REM_W-2:0], x_r[IDX_BITS-1 -: 2]};
    trial    = (REM_W+1)'({root_r, 2'b01});
    if (start) begin
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[IDX_BITS-3:0], 2'b00};
      if (sh >= trial) begin
        rem_nxt  = REM_W'(sh - trial);
        root_nxt = {root_r[SQ_W-2:0], 1'b1};
      end else begin
        rem_nxt  = sh[REM_W-1:0];
        root_nxt = {root_r[SQ_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SQ_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hw/rtl/fip_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_mix: add-rotate-xor mixer
// Key xor on start, then one add or xor step per cycle; done after 4 steps.
// ----------------------------------------------------------------------------
module fip_mix import fip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] value,
  input  logic [WORD_W-1:0] key,
  output logic              done,
  output logic [WORD_W-1:0] mixed
);

  logic [WORD_W-1:0] v_r, v_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    v_nxt    = v_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = value ^ key;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      case (step_r)
        2'd0:    v_nxt = v_r + {v_r[16:0], v_r[63:17]};
        2'd1:    v_nxt = v_r ^ {v_r[30:0], v_r[63:31]};
        2'd2:    v_nxt = v_r + {v_r[22:0], v_r[63:23]};
        default: v_nxt = v_r ^ {v_r[46:0], v_r[63:47]};
      endcase
      step_nxt = step_r + 1'b1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done  = done_r;
  assign mixed = v_r;

endmodule

// ----- hw/rtl/feistel_index_permutation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feistel_index_permutation: keyed index permutation
// Feistel network over an a-by-b rectangle with cycle walking.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in_ch    in   valid/ready           index[47:0]
//  out_ch   out  valid/ready           permuted[47:0]
//  cfg_*    in   cfg_we (no back-off)  cfg_index[0], cfg_data[63:0]
//
//  One index at a time. Each walk pass is a split (serial divide), then per
//  round a mix and a serial divide, then the recombine (multiply, check);
//  an index at or above range is first reduced modulo range by a divide.
//  The bit-serial divider is the slowest step.
//  A seed write starts key derivation; a range write starts the square root
//  that sizes the sides. After reset the seed-zero keys are derived first.
//  A finished result waits in the output register; the next index is
//  taken meanwhile, and the block stalls only if a second result is ready.
// ----------------------------------------------------------------------------
module feistel_index_permutation import fip_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fip_in_if.sink               in_ch,
  fip_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_KEYS  = 12'b0000_0000_0010,
    ST_SQRT  = 12'b0000_0000_0100,
    ST_SQMUL = 12'b0000_0000_1000,
    ST_SQCHK = 12'b0000_0001_0000,
    ST_RED   = 12'b0000_0010_0000,
    ST_SPLIT = 12'b0000_0100_0000,
    ST_MIX   = 12'b0000_1000_0000,
    ST_MOD   = 12'b0001_0000_0000,
    ST_MUL   = 12'b0010_0000_0000,
    ST_CHK   = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic                kick_r, kick_nxt;         // start pulse for the unit of the new state
  logic [WORD_W-1:0]   seed_r, seed_nxt;
  logic [RNG_W-1:0]    range_r, range_nxt;
  logic                keys_pend_r, keys_pend_nxt;
  logic                sides_pend_r, sides_pend_nxt;
  logic [WORD_W-1:0]   key_r [4];
  logic [WORD_W-1:0]   key_nxt [4];
  logic [1:0]          kidx_r, kidx_nxt;
  logic [RNG_W-1:0]    eff_r, eff_nxt;
  logic [SIDE_W-1:0]   side_a_r, side_a_nxt;
  logic [SIDE_W-1:0]   side_b_r, side_b_nxt;
  logic [RNG_W-1:0]    x_r, x_nxt;
  logic [SIDE_W-1:0]   left_r, left_nxt;
  logic [SIDE_W-1:0]   right_r, right_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [IDX_BITS-1:0] res_r, res_nxt;
  logic [IDX_BITS-1:0] out_perm_r, out_perm_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_rdy;
  logic                in_xfer;
  logic [RNG_W-1:0]    eff_calc;

  // shared units
  logic                div_done;
  logic [WORD_W-1:0]   div_dvd;
  logic [RNG_W-1:0]    div_dvs;
  logic [WORD_W-1:0]   div_q;
  logic [RNG_W-1:0]    div_rem;
  logic                mix_done;
  logic [WORD_W-1:0]   mix_val;
  logic [WORD_W-1:0]   mix_key;
  logic [WORD_W-1:0]   mix_out;
  logic                sq_done;
  logic [SQ_W-1:0]     sq_root;
  logic [SIDE_W-1:0]   mul_x;
  logic [SIDE_W-1:0]   mul_y;
  logic [SIDE_W-1:0]   rnd_mod;
  logic [SIDE_W-1:0]   rnd_old;
  logic [SIDE_W:0]     rnd_sum;
  logic [PROD_W:0]     walk_res;

  // clamp range to [1, 2^IDX_BITS]
  always_comb begin
    if (range_r == '0) begin
      eff_calc = RNG_W'(1);
    end else if (range_r > EFF_MAX) begin
      eff_calc = EFF_MAX;
    end else begin
      eff_calc = range_r;
    end
  end

  // operand steering for the divider, mixer and multiplier
  always_comb begin
    div_dvd = {{(WORD_W-RNG_W){1'b0}}, x_r};
    div_dvs = eff_r;
    if (state_r == ST_SPLIT) begin
      div_dvs = RNG_W'(side_b_r);
    end else if (state_r == ST_MOD) begin
      div_dvd = mix_out;
      div_dvs = rnd_r[0] ? RNG_W'(side_b_r) : RNG_W'(side_a_r);
    end
    if (state_r == ST_KEYS) begin
      mix_val = (kidx_r == 2'd0) ? seed_r : (seed_r ^ key_r[kidx_r - 2'd1]);
      mix_key = key_salt(kidx_r);
    end else begin
      mix_val = rnd_r[0] ? WORD_W'(left_r) : WORD_W'(right_r);
      mix_key = key_r[rnd_r[1:0]] ^ WORD_W'(rnd_r);
    end
    if (state_r == ST_SQMUL) begin
      mul_x = side_a_r - 1'b1;
      mul_y = side_a_r;
    end else begin
      mul_x = left_r;
      mul_y = side_b_r;
    end
  end

  // round update: (old + f mod side) mod side, both terms below side
  assign rnd_mod  = rnd_r[0] ? side_b_r : side_a_r;
  assign rnd_old  = rnd_r[0] ? right_r : left_r;
  assign rnd_sum  = {1'b0, rnd_old} + {1'b0, div_rem[SIDE_W-1:0]};
  assign walk_res = {1'b0, prod_r} + (PROD_W+1)'(right_r);

  assign in_rdy  = (state_r == ST_IDLE) && !keys_pend_r && !sides_pend_r && !cfg_we;
  assign in_xfer = in_ch.valid && in_rdy;

  always_comb begin
    state_nxt      = state_r;
    kick_nxt       = 1'b0;
    seed_nxt       = seed_r;
    range_nxt      = range_r;
    keys_pend_nxt  = keys_pend_r;
    sides_pend_nxt = sides_pend_r;
    key_nxt        = key_r;
    kidx_nxt       = kidx_r;
    eff_nxt        = eff_r;
    side_a_nxt     = side_a_r;
    side_b_nxt     = side_b_r;
    x_nxt          = x_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    rnd_nxt        = rnd_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    out_perm_nxt   = out_perm_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (keys_pend_r) begin
          keys_pend_nxt = 1'b0;
          kidx_nxt      = '0;
          kick_nxt      = 1'b1;
          state_nxt     = ST_KEYS;
        end else if (sides_pend_r) begin
          sides_pend_nxt = 1'b0;
          eff_nxt        = eff_calc;
          kick_nxt       = 1'b1;
          state_nxt      = ST_SQRT;
        end else if (in_xfer) begin
          x_nxt     = {1'b0, in_ch.index};
          kick_nxt  = 1'b1;
          state_nxt = ({1'b0, in_ch.index} >= eff_r) ? ST_RED : ST_SPLIT;
        end
      end
      ST_KEYS: begin
        if (mix_done) begin
          key_nxt[kidx_r] = mix_out;
          if (kidx_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end else begin
            kidx_nxt = kidx_r + 2'd1;
            kick_nxt = 1'b1;
          end
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          side_a_nxt = SIDE_W'(sq_root) + 1'b1;
          state_nxt  = ST_SQMUL;
        end
      end
      ST_SQMUL: begin
        prod_nxt  = mul_x * mul_y;
        state_nxt = ST_SQCHK;
      end
      ST_SQCHK: begin
        // b = a-1 when (a-1)*a already covers the range
        if (side_a_r > SIDE_W'(1) && prod_r >= PROD_W'(eff_r)) begin
          side_b_nxt = side_a_r - 1'b1;
        end else begin
          side_b_nxt = side_a_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_RED: begin
        if (div_done) begin
          x_nxt     = div_rem;
          kick_nxt  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (div_done) begin
          left_nxt  = div_q[SIDE_W-1:0];
          right_nxt = div_rem[SIDE_W-1:0];
          rnd_nxt   = '0;
          kick_nxt  = 1'b1;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (mix_done) begin
          kick_nxt  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          if (rnd_r[0]) begin
            right_nxt = (rnd_sum >= {1'b0, rnd_mod}) ? SIDE_W'(rnd_sum - {1'b0, rnd_mod})
                                                      : rnd_sum[SIDE_W-1:0];
          end else begin
            left_nxt = (rnd_sum >= {1'b0, rnd_mod}) ? SIDE_W'(rnd_sum - {1'b0, rnd_mod})
                                                     : rnd_sum[SIDE_W-1:0];
          end
          if (rnd_r == RND_W'(ROUND_COUNT - 1)) begin
            state_nxt = ST_MUL;
          end else begin
            rnd_nxt   = rnd_r + 1'b1;
            kick_nxt  = 1'b1;
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = mul_x * mul_y;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // cycle walk: outside the domain, go round again
        if (walk_res >= (PROD_W+1)'(eff_r)) begin
          x_nxt     = walk_res[RNG_W-1:0];
          kick_nxt  = 1'b1;
          state_nxt = ST_SPLIT;
        end else begin
          res_nxt   = walk_res[IDX_BITS-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_perm_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED: begin
          seed_nxt      = cfg_data;
          keys_pend_nxt = 1'b1;
        end
        CFG_RANGE: begin
          range_nxt      = cfg_data[RNG_W-1:0];
          sides_pend_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    kidx_r     <= kidx_nxt;
    x_r        <= x_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    rnd_r      <= rnd_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_perm_r <= out_perm_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      kick_r       <= 1'b0;
      seed_r       <= '0;
      range_r      <= RNG_W'(1);
      keys_pend_r  <= 1'b1;      // derive the seed-zero keys after reset
      sides_pend_r <= 1'b0;
      eff_r        <= RNG_W'(1);
      side_a_r     <= SIDE_W'(1);
      side_b_r     <= SIDE_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kick_r       <= kick_nxt;
      seed_r       <= seed_nxt;
      range_r      <= range_nxt;
      keys_pend_r  <= keys_pend_nxt;
      sides_pend_r <= sides_pend_nxt;
      eff_r        <= eff_nxt;
      side_a_r     <= side_a_nxt;
      side_b_r     <= side_b_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  fip_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kick_r && (state_r == ST_RED || state_r == ST_SPLIT || state_r == ST_MOD)),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  fip_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kick_r && (state_r == ST_KEYS || state_r == ST_MIX)),
    .value (mix_val),
    .key   (mix_key),
    .done  (mix_done),
    .mixed (mix_out)
  );

  fip_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kick_r && state_r == ST_SQRT),
    .radicand (IDX_BITS'(eff_r - 1'b1)),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign in_ch.ready     = in_rdy;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.permuted = out_perm_r;

endmodule
